FILE: design/bmc_pkg.sv
`timescale 1ns / 1ps

package bmc_pkg;

	// table and read geometry
	localparam int TABLE_DEPTH = 64;
	localparam int MAX_BASES   = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int BASE_W      = 2 * MAX_BASES;
	localparam int LEN_W       = $clog2(MAX_BASES + 1);
	localparam int MM_W        = LEN_W + 1;

	// reduction tree grouping
	localparam int GROUP  = 8;
	localparam int NGROUP = (TABLE_DEPTH + GROUP - 1) / GROUP;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// stream payload widths
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAIRED_MODE  = 3'd0,
		REG_BARCODE1_LEN = 3'd1,
		REG_BARCODE2_LEN = 3'd2,
		REG_MAX_TOTAL_MM = 3'd3,
		REG_MAX_READ1_MM = 3'd4,
		REG_MAX_READ2_MM = 3'd5,
		REG_ENTRY_COUNT  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_MATCH        = 2'd0,
		ST_UNIDENTIFIED = 2'd1,
		ST_AMBIGUOUS    = 2'd2,
		ST_LOAD_DONE    = 2'd3
	} status_t;

	localparam logic FUNC_LOAD     = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	// per-lane strobes
	typedef struct packed {
		logic wr;
		logic en1;
		logic en2;
	} lane_ctrl_t;

	// per-item compare masks, shared by all lanes in stage 1
	typedef struct packed {
		logic [MAX_BASES-1:0] mask1;
		logic [MAX_BASES-1:0] mask2;
		logic [LEN_W-1:0]     miss2;
	} score_cfg_t;

	// qualification limits, shared by all lanes in stage 2
	typedef struct packed {
		logic             paired;
		logic             too_short;
		logic [MM_W-1:0]  lim1;
		logic [MM_W-1:0]  total;
		logic [LEN_W-1:0] lim2r;
	} qual_cfg_t;

	// reduction tree node
	typedef struct packed {
		logic             ok;
		logic             multi;
		logic [MM_W-1:0]  mm;
		logic [IDX_W-1:0] idx;
	} node_t;

	// count of set bits over one barcode's worth of base flags
	function automatic logic [LEN_W-1:0] popcount(input logic [MAX_BASES-1:0] v);
		logic [LEN_W-1:0] c;
		c = '0;
		for (int i = 0; i < MAX_BASES; i++) begin
			c = c + LEN_W'(v[i]);
		end
		return c;
	endfunction

	// keep the lower count, flag a tie
	function automatic node_t node_merge(input node_t a, input node_t b);
		node_t r;
		r = a;
		if (!a.ok) begin
			r = b;
		end else if (!b.ok) begin
			r = a;
		end else if (a.mm < b.mm) begin
			r = a;
		end else if (b.mm < a.mm) begin
			r = b;
		end else begin
			r = a;
			r.multi = 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: design/bmc_lane.sv
`timescale 1ns / 1ps

module bmc_lane (
	input  logic                               clk,
	input  bmc_pkg::lane_ctrl_t                ctrl,
	input  logic [bmc_pkg::BASE_W-1:0]         seq1_bases,
	input  logic [bmc_pkg::BASE_W-1:0]         seq2_bases,
	input  bmc_pkg::score_cfg_t                score,
	input  bmc_pkg::qual_cfg_t                 qual,
	input  logic                               in_use,
	output logic                               ok,
	output logic [bmc_pkg::MM_W-1:0]           sum
);

	logic [bmc_pkg::BASE_W-1:0]    first_q;
	logic [bmc_pkg::BASE_W-1:0]    second_q;
	logic [bmc_pkg::MAX_BASES-1:0] diff1;
	logic [bmc_pkg::MAX_BASES-1:0] diff2;
	logic [bmc_pkg::LEN_W-1:0]     m1_s1;
	logic [bmc_pkg::LEN_W-1:0]     m2_s1;
	logic [bmc_pkg::MM_W-1:0]      lim2;
	logic [bmc_pkg::MM_W-1:0]      rem;
	logic                          ok1;
	logic                          ok2;
	logic                          ok_s2;
	logic [bmc_pkg::MM_W-1:0]      sum_s2;

	// barcode pair storage for this entry
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			first_q  <= seq1_bases;
			second_q <= seq2_bases;
		end
	end

	// per-base mismatch flags inside the compare window
	always_comb begin
		for (int i = 0; i < bmc_pkg::MAX_BASES; i++) begin
			diff1[i] = score.mask1[i] && (first_q[2*i +: 2] != seq1_bases[2*i +: 2]);
			diff2[i] = score.mask2[i] && (second_q[2*i +: 2] != seq2_bases[2*i +: 2]);
		end
	end

	// stage 1: mismatch counts
	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			m1_s1 <= bmc_pkg::popcount(diff1);
			m2_s1 <= bmc_pkg::popcount(diff2) + score.miss2;
		end
	end

	// limits; read-2 limit shrinks by what read 1 used
	always_comb begin
		rem  = qual.total - bmc_pkg::MM_W'(m1_s1);
		lim2 = (rem < bmc_pkg::MM_W'(qual.lim2r)) ? rem : bmc_pkg::MM_W'(qual.lim2r);
		ok1  = in_use && !qual.too_short && (bmc_pkg::MM_W'(m1_s1) <= qual.lim1);
		ok2  = !qual.paired || (bmc_pkg::MM_W'(m2_s1) <= lim2);
	end

	// stage 2: qualify and total
	always_ff @(posedge clk) begin
		if (ctrl.en2) begin
			ok_s2  <= ok1 && ok2;
			sum_s2 <= bmc_pkg::MM_W'(m1_s1)
				+ (qual.paired ? bmc_pkg::MM_W'(m2_s1) : '0);
		end
	end

	assign ok  = ok_s2;
	assign sum = sum_s2;

endmodule

FILE: design/bmc_reduce.sv
`timescale 1ns / 1ps

module bmc_reduce (
	input  logic                        clk,
	input  logic                        en3,
	input  logic [bmc_pkg::TABLE_DEPTH-1:0] ok,
	input  logic [bmc_pkg::MM_W-1:0]    sum [bmc_pkg::TABLE_DEPTH],
	output bmc_pkg::node_t              best
);

	bmc_pkg::node_t leaf   [bmc_pkg::NGROUP*bmc_pkg::GROUP];
	bmc_pkg::node_t grp    [bmc_pkg::NGROUP];
	bmc_pkg::node_t grp_s3 [bmc_pkg::NGROUP];

	// leaves carry their entry number; padding leaves never qualify
	for (genvar e = 0; e < bmc_pkg::NGROUP * bmc_pkg::GROUP; e++) begin : g_leaf
		if (e < bmc_pkg::TABLE_DEPTH) begin : g_real
			assign leaf[e] = '{ok: ok[e], multi: 1'b0, mm: sum[e],
				idx: bmc_pkg::IDX_W'(e)};
		end else begin : g_pad
			assign leaf[e] = '{ok: 1'b0, multi: 1'b0, mm: '0, idx: '0};
		end
	end

	// first level: best of each group
	always_comb begin
		for (int g = 0; g < bmc_pkg::NGROUP; g++) begin
			grp[g] = leaf[g*bmc_pkg::GROUP];
			for (int k = 1; k < bmc_pkg::GROUP; k++) begin
				grp[g] = bmc_pkg::node_merge(grp[g], leaf[g*bmc_pkg::GROUP + k]);
			end
		end
	end

	// stage 3: group winners
	always_ff @(posedge clk) begin
		if (en3) begin
			for (int g = 0; g < bmc_pkg::NGROUP; g++) begin
				grp_s3[g] <= grp[g];
			end
		end
	end

	// second level: best over the groups
	always_comb begin
		best = grp_s3[0];
		for (int g = 1; g < bmc_pkg::NGROUP; g++) begin
			best = bmc_pkg::node_merge(best, grp_s3[g]);
		end
	end

endmodule

FILE: design/barcode_mismatch_classifier_core.sv
`timescale 1ns / 1ps

// Barcode classifier. Each input transfer is either a load (tuser 0), which
// writes one barcode pair into the 64-entry table, or a classify (tuser 1),
// which scores a read pair against every entry in use and reports a unique
// best match, a tie (ambiguous) or no qualifying entry (unidentified). Every
// input transfer yields exactly one output transfer. The table is held as
// one register lane per entry, each with its own comparators, so a new item
// can be taken every cycle while the output is not stalled; a result passes
// through four register stages (mismatch count, qualify, group reduce, final
// reduce into the output register), and a stall on the output holds every
// stage in place. A load is seen by the very next classify. Entries that were
// never loaded hold unknown contents.
// Configuration may only be written while no item is in flight.
module barcode_mismatch_classifier_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [bmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bmc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// entry_index[5:0], seq1_bases[37:6], seq2_bases[69:38],
	// seq1_avail[74:70], seq2_avail[79:75]
	input  logic [bmc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func[0]
	input  logic                             s_axis_tuser,
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// match_index[5:0], match_mm[11:6], zero[15:12]
	output logic [bmc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// status[1:0]
	output logic [1:0]                       m_axis_tuser
);

	// configuration registers
	logic       paired_mode_q;
	logic [4:0] barcode1_len_q;
	logic [4:0] barcode2_len_q;
	logic [5:0] max_total_mm_q;
	logic [4:0] max_read1_mm_q;
	logic [4:0] max_read2_mm_q;
	logic [6:0] entry_count_q;

	// input fields
	logic [bmc_pkg::IDX_W-1:0]  entry_index;
	logic [bmc_pkg::BASE_W-1:0] seq1_bases;
	logic [bmc_pkg::BASE_W-1:0] seq2_bases;
	logic [4:0]                 seq1_avail;
	logic [4:0]                 seq2_avail;

	// pipeline control
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4;
	logic accept;
	logic func_s1, func_s2, func_s3;
	logic too_short_s1;

	// shared per-item terms
	logic [bmc_pkg::LEN_W-1:0] len1;
	logic [bmc_pkg::LEN_W-1:0] len2;
	logic [bmc_pkg::LEN_W-1:0] chk2;
	logic                      too_short;
	bmc_pkg::score_cfg_t       score;
	bmc_pkg::qual_cfg_t        qual;

	// lane results
	logic [bmc_pkg::TABLE_DEPTH-1:0] lane_ok;
	logic [bmc_pkg::MM_W-1:0]        lane_sum [bmc_pkg::TABLE_DEPTH];
	bmc_pkg::node_t                  best;

	// output register
	bmc_pkg::status_t           status_s4;
	logic [bmc_pkg::IDX_W-1:0]  match_index_s4;
	logic [bmc_pkg::MM_W-1:0]   match_mm_s4;

	assign entry_index = s_axis_tdata[5:0];
	assign seq1_bases  = s_axis_tdata[37:6];
	assign seq2_bases  = s_axis_tdata[69:38];
	assign seq1_avail  = s_axis_tdata[74:70];
	assign seq2_avail  = s_axis_tdata[79:75];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paired_mode_q  <= 1'b0;
			barcode1_len_q <= 5'd8;
			barcode2_len_q <= 5'd8;
			max_total_mm_q <= 6'd1;
			max_read1_mm_q <= 5'd1;
			max_read2_mm_q <= 5'd1;
			entry_count_q  <= 7'd1;
		end else if (cfg_we) begin
			unique case (bmc_pkg::cfg_reg_t'(cfg_index))
				bmc_pkg::REG_PAIRED_MODE:  paired_mode_q  <= cfg_data[0];
				bmc_pkg::REG_BARCODE1_LEN: barcode1_len_q <= cfg_data[4:0];
				bmc_pkg::REG_BARCODE2_LEN: barcode2_len_q <= cfg_data[4:0];
				bmc_pkg::REG_MAX_TOTAL_MM: max_total_mm_q <= cfg_data[5:0];
				bmc_pkg::REG_MAX_READ1_MM: max_read1_mm_q <= cfg_data[4:0];
				bmc_pkg::REG_MAX_READ2_MM: max_read2_mm_q <= cfg_data[4:0];
				bmc_pkg::REG_ENTRY_COUNT:  entry_count_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// stall chain: a stage loads when it is empty or its successor moves
	assign en4           = !v4_s4 || m_axis_tready;
	assign en3           = !v3_s3 || en4;
	assign en2           = !v2_s2 || en3;
	assign en1           = !v1_s1 || en2;
	assign s_axis_tready = en1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= accept;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	// compare windows and limits; lengths saturate at the barcode size
	always_comb begin
		len1 = (barcode1_len_q > 5'(bmc_pkg::MAX_BASES))
			? bmc_pkg::LEN_W'(bmc_pkg::MAX_BASES) : bmc_pkg::LEN_W'(barcode1_len_q);
		len2 = (barcode2_len_q > 5'(bmc_pkg::MAX_BASES))
			? bmc_pkg::LEN_W'(bmc_pkg::MAX_BASES) : bmc_pkg::LEN_W'(barcode2_len_q);
		chk2 = (5'(len2) < seq2_avail) ? len2 : bmc_pkg::LEN_W'(seq2_avail);
		too_short = seq1_avail < 5'(len1);
		for (int i = 0; i < bmc_pkg::MAX_BASES; i++) begin
			score.mask1[i] = 5'(i) < 5'(len1);
			score.mask2[i] = 5'(i) < 5'(chk2);
		end
		score.miss2     = len2 - chk2;
		qual.paired     = paired_mode_q;
		qual.too_short  = too_short_s1;
		qual.total      = bmc_pkg::MM_W'(max_total_mm_q);
		qual.lim1       = (max_total_mm_q < 6'(max_read1_mm_q))
			? bmc_pkg::MM_W'(max_total_mm_q) : bmc_pkg::MM_W'(max_read1_mm_q);
		qual.lim2r      = bmc_pkg::LEN_W'(max_read2_mm_q);
	end

	// item tags that travel with the pipeline
	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1      <= s_axis_tuser;
			too_short_s1 <= too_short;
		end
		if (en2) func_s2 <= func_s1;
		if (en3) func_s3 <= func_s2;
	end

	// one lane per table entry
	for (genvar e = 0; e < bmc_pkg::TABLE_DEPTH; e++) begin : g_lane
		bmc_pkg::lane_ctrl_t ctrl;
		logic                in_use;

		assign ctrl.wr  = accept && (s_axis_tuser == bmc_pkg::FUNC_LOAD)
			&& (entry_index == bmc_pkg::IDX_W'(e));
		assign ctrl.en1 = en1;
		assign ctrl.en2 = en2;
		assign in_use   = 7'(e) < entry_count_q;

		bmc_lane u_lane (
			.clk        (clk),
			.ctrl       (ctrl),
			.seq1_bases (seq1_bases),
			.seq2_bases (seq2_bases),
			.score      (score),
			.qual       (qual),
			.in_use     (in_use),
			.ok         (lane_ok[e]),
			.sum        (lane_sum[e])
		);
	end

	bmc_reduce u_reduce (
		.clk  (clk),
		.en3  (en3),
		.ok   (lane_ok),
		.sum  (lane_sum),
		.best (best)
	);

	// stage 4: result coding into the output register
	always_ff @(posedge clk) begin
		if (en4) begin
			if (func_s3 == bmc_pkg::FUNC_LOAD) begin
				status_s4      <= bmc_pkg::ST_LOAD_DONE;
				match_index_s4 <= '0;
				match_mm_s4    <= '0;
			end else if (!best.ok) begin
				status_s4      <= bmc_pkg::ST_UNIDENTIFIED;
				match_index_s4 <= '0;
				match_mm_s4    <= '0;
			end else if (best.multi) begin
				status_s4      <= bmc_pkg::ST_AMBIGUOUS;
				match_index_s4 <= '0;
				match_mm_s4    <= best.mm;
			end else begin
				status_s4      <= bmc_pkg::ST_MATCH;
				match_index_s4 <= best.idx;
				match_mm_s4    <= best.mm;
			end
		end
	end

	assign m_axis_tvalid = v4_s4;
	assign m_axis_tuser  = status_s4;
	assign m_axis_tdata  = {4'b0000, match_mm_s4, match_index_s4};

endmodule

FILE: bench/barcode_mismatch_classifier_core_test.sv
`timescale 1ns / 1ps

module barcode_mismatch_classifier_core_test;
	import bmc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// one input transfer, fields in packing order
	typedef struct {
		logic                 func;
		logic [IDX_W-1:0]     entry;
		logic [BASE_W-1:0]    seq1;
		logic [BASE_W-1:0]    seq2;
		logic [4:0]           avail1;
		logic [4:0]           avail2;
	} read_item_t;

	// one output transfer
	typedef struct {
		status_t              status;
		logic [IDX_W-1:0]     index;
		logic [MM_W-1:0]      mm;
	} outcome_t;

	// register settings in port order
	typedef struct {
		logic                 paired;
		logic [4:0]           len1;
		logic [4:0]           len2;
		logic [5:0]           total;
		logic [4:0]           lim1;
		logic [4:0]           lim2;
		logic [6:0]           count;
	} bmc_cfg_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [IN_DATA_W-1:0]     s_axis_tdata;
	logic                     s_axis_tuser;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [OUT_DATA_W-1:0]    m_axis_tdata;
	logic [1:0]               m_axis_tuser;

	// shadow copy of the barcode table and the registers
	logic [BASE_W-1:0]        code1_mem [TABLE_DEPTH];
	logic [BASE_W-1:0]        code2_mem [TABLE_DEPTH];
	bmc_cfg_t                 active_cfg;

	outcome_t                 pending_outcomes [$];
	int                       mismatch_count = 0;
	int                       cycle_count = 0;
	logic                     sender_steady = 1'b0;
	logic                     sink_steady = 1'b0;

	barcode_mismatch_classifier_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// differing bases among the first n
	function automatic int base_mismatches(input logic [BASE_W-1:0] a,
			input logic [BASE_W-1:0] b, input int n);
		int diffs;
		diffs = 0;
		for (int i = 0; i < n; i++) begin
			if (a[2*i +: 2] != b[2*i +: 2])
				diffs++;
		end
		return diffs;
	endfunction

	// best entry for one read pair under the current settings
	function automatic outcome_t score_read(input logic [BASE_W-1:0] r1,
			input logic [BASE_W-1:0] r2, input logic [4:0] av1, input logic [4:0] av2);
		int len1, len2, lim1, lim2, n, m1, m2, chk, sum;
		int best_mm, best_idx, best_cnt;
		logic ok;
		outcome_t o;
		len1 = min_int(int'(active_cfg.len1), MAX_BASES);
		len2 = min_int(int'(active_cfg.len2), MAX_BASES);
		lim1 = min_int(int'(active_cfg.total), int'(active_cfg.lim1));
		n = min_int(int'(active_cfg.count), TABLE_DEPTH);
		best_mm = 0;
		best_idx = 0;
		best_cnt = 0;
		if (int'(av1) >= len1) begin
			for (int e = 0; e < n; e++) begin
				m1 = base_mismatches(code1_mem[e], r1, len1);
				ok = (m1 <= lim1);
				sum = m1;
				if (ok && active_cfg.paired) begin
					lim2 = min_int(int'(active_cfg.total) - m1, int'(active_cfg.lim2));
					chk = min_int(len2, int'(av2));
					m2 = (len2 - chk) + base_mismatches(code2_mem[e], r2, chk);
					ok = (m2 <= lim2);
					sum = m1 + m2;
				end
				if (ok) begin
					if (best_cnt == 0 || sum < best_mm) begin
						best_mm = sum;
						best_idx = e;
						best_cnt = 1;
					end else if (sum == best_mm) begin
						best_cnt++;
					end
				end
			end
		end
		if (best_cnt == 0) begin
			o = '{ST_UNIDENTIFIED, '0, '0};
		end else if (best_cnt == 1) begin
			o = '{ST_MATCH, IDX_W'(best_idx), MM_W'(best_mm)};
		end else begin
			o = '{ST_AMBIGUOUS, '0, MM_W'(best_mm)};
		end
		return o;
	endfunction

	// change k random bases within the first span
	function automatic logic [BASE_W-1:0] mutate_bases(input logic [BASE_W-1:0] s,
			input int k, input int span);
		int pos;
		if (span <= 0)
			return s;
		for (int j = 0; j < k; j++) begin
			pos = $urandom_range(0, span - 1);
			s[2*pos +: 2] = s[2*pos +: 2] ^ 2'($urandom_range(1, 3));
		end
		return s;
	endfunction

	function automatic logic [BASE_W-1:0] prefix_mask(input int len);
		if (len >= MAX_BASES)
			return '1;
		return (BASE_W'(1) << (2 * len)) - 1;
	endfunction

	// mostly lo..hi, now and then zero or the top of the register
	function automatic int draw_setting(input int lo, input int hi, input int top);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return top;
		return $urandom_range(lo, hi);
	endfunction

	function automatic read_item_t load_item(input int idx, input logic [BASE_W-1:0] s1,
			input logic [BASE_W-1:0] s2);
		return '{FUNC_LOAD, IDX_W'(idx), s1, s2, 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31))};
	endfunction

	function automatic read_item_t read_pair(input logic [BASE_W-1:0] s1,
			input logic [BASE_W-1:0] s2, input int av1, input int av2);
		return '{FUNC_CLASSIFY, IDX_W'($urandom_range(0, 63)), s1, s2, 5'(av1), 5'(av2)};
	endfunction

	// append one expected outcome behind the ones still waiting
	task automatic queue_outcome(input outcome_t o);
		pending_outcomes.insert(pending_outcomes.size(), o);
	endtask

	// send one item, then update the shadow state and queue its outcome
	task automatic send_item(input read_item_t it);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {it.avail2, it.avail1, it.seq2, it.seq1, it.entry};
		s_axis_tuser <= it.func;
		do @(posedge clk); while (!s_axis_tready);
		if (it.func == FUNC_LOAD) begin
			code1_mem[it.entry] = it.seq1;
			code2_mem[it.entry] = it.seq2;
			queue_outcome('{ST_LOAD_DONE, '0, '0});
		end else begin
			queue_outcome(score_read(it.seq1, it.seq2, it.avail1, it.avail2));
		end
	endtask

	// hold the input and wait for every outstanding result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input int v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= CFG_DATA_W'(v);
		@(posedge clk);
	endtask

	task automatic apply_config(input bmc_cfg_t c);
		drain_results();
		write_reg(REG_PAIRED_MODE, int'(c.paired));
		write_reg(REG_BARCODE1_LEN, int'(c.len1));
		write_reg(REG_BARCODE2_LEN, int'(c.len2));
		write_reg(REG_MAX_TOTAL_MM, int'(c.total));
		write_reg(REG_MAX_READ1_MM, int'(c.lim1));
		write_reg(REG_MAX_READ2_MM, int'(c.lim2));
		write_reg(REG_ENTRY_COUNT, int'(c.count));
		cfg_we <= 1'b0;
		active_cfg = c;
	endtask

	logic [BASE_W-1:0] anchor1;
	logic [BASE_W-1:0] anchor2;

	// default settings: one entry, length 8, one mismatch allowed
	task automatic test_reset_values();
		anchor1 = $urandom;
		anchor2 = $urandom;
		send_item(load_item(0, anchor1, anchor2));
		send_item(read_pair(anchor1, $urandom, 16, 16));
		send_item(read_pair(anchor1 ^ (32'h1 << 6), $urandom, 16, 16));
		send_item(read_pair(anchor1 ^ (32'h1 << 6) ^ (32'h2 << 10), $urandom, 16, 16));
		send_item(read_pair(anchor1, $urandom, 7, 16));
		// bases past the barcode length do not count
		send_item(read_pair(anchor1 ^ (32'h3 << 20), $urandom, 16, 16));
	endtask

	// duplicate barcodes, all-A and all-T entries, count zero, length saturation
	task automatic test_ties_and_extremes();
		send_item(load_item(1, anchor1, $urandom));
		send_item(load_item(2, '1, '1));
		send_item(load_item(3, '0, '0));
		send_item(load_item(63, '1, '0));
		apply_config('{1'b0, 5'd16, 5'd16, 6'd32, 5'd16, 5'd16, 7'd4});
		send_item(read_pair(anchor1, '0, 16, 0));
		send_item(read_pair('1, '1, 31, 31));
		send_item(read_pair('0, '0, 16, 0));
		send_item(read_pair(anchor1, '0, 15, 0));
		apply_config('{1'b0, 5'd16, 5'd16, 6'd32, 5'd16, 5'd16, 7'd0});
		send_item(read_pair(anchor1, '0, 16, 0));
		apply_config('{1'b0, 5'd31, 5'd16, 6'd63, 5'd31, 5'd16, 7'd4});
		send_item(read_pair('1, '0, 16, 0));
		send_item(read_pair('1, '0, 15, 0));
	endtask

	// second barcode scoring, including missing read-2 bases
	task automatic test_paired_scoring();
		apply_config('{1'b1, 5'd8, 5'd8, 6'd3, 5'd2, 5'd2, 7'd4});
		send_item(read_pair(anchor1, anchor2, 16, 16));
		send_item(read_pair(anchor1, anchor2, 16, 6));
		send_item(read_pair(anchor1, anchor2, 16, 5));
		send_item(read_pair(anchor1 ^ 32'h1, anchor2 ^ 32'h4, 16, 16));
		send_item(read_pair(anchor1, anchor2, 16, 0));
		apply_config('{1'b1, 5'd8, 5'd0, 6'd3, 5'd2, 5'd2, 7'd4});
		send_item(read_pair(anchor1, $urandom, 16, 0));
		apply_config('{1'b1, 5'd8, 5'd31, 6'd63, 5'd31, 5'd31, 7'd4});
		send_item(read_pair(anchor1, anchor2, 16, 31));
	endtask

	// zero first length: every entry scores zero on read 1
	task automatic test_zero_length();
		apply_config('{1'b0, 5'd0, 5'd8, 6'd1, 5'd1, 5'd1, 7'd1});
		send_item(read_pair($urandom, $urandom, 0, 16));
		apply_config('{1'b0, 5'd0, 5'd8, 6'd1, 5'd1, 5'd1, 7'd3});
		send_item(read_pair($urandom, $urandom, 16, 16));
	endtask

	// load every entry, some close to earlier ones so that ties occur
	task automatic test_table_fill();
		int j;
		for (int e = 0; e < TABLE_DEPTH; e++) begin
			if (e > 0 && $urandom_range(0, 3) == 0) begin
				j = $urandom_range(0, e - 1);
				send_item(load_item(e, mutate_bases(code1_mem[j], $urandom_range(0, 2), 16),
					mutate_bases(code2_mem[j], $urandom_range(0, 2), 16)));
			end else begin
				send_item(load_item(e, $urandom, $urandom));
			end
		end
	endtask

	// reads drawn mostly from entries in use, with some loads and noise
	task automatic test_random_reads();
		bmc_cfg_t c;
		int len1, len2, n_used, e, r, j, av1, av2;
		logic [BASE_W-1:0] s1, s2, m1, m2;
		for (int phase = 0; phase < 13; phase++) begin
			if (phase == 0) begin
				c = '{1'b0, 5'd1, 5'd0, 6'd0, 5'd0, 5'd0, 7'd1};
			end else if (phase == 1) begin
				c = '{1'b1, 5'd31, 5'd31, 6'd63, 5'd31, 5'd31, 7'd127};
			end else if (phase == 2) begin
				c = '{1'b1, 5'd16, 5'd16, 6'd32, 5'd16, 5'd16, 7'd64};
			end else begin
				c.paired = 1'($urandom_range(0, 1));
				c.len1 = 5'(draw_setting(3, 12, 31));
				c.len2 = 5'(draw_setting(2, 12, 31));
				c.total = 6'(draw_setting(0, 6, 63));
				c.lim1 = 5'(draw_setting(0, 4, 31));
				c.lim2 = 5'(draw_setting(0, 4, 31));
				c.count = 7'(draw_setting(1, 12, 127));
			end
			apply_config(c);
			sender_steady = (phase % 4 == 2) || (phase % 4 == 3);
			sink_steady = (phase % 4 == 2);
			len1 = min_int(int'(c.len1), MAX_BASES);
			len2 = min_int(int'(c.len2), MAX_BASES);
			n_used = min_int(int'(c.count), TABLE_DEPTH);
			if (n_used == 0)
				n_used = TABLE_DEPTH;
			m1 = prefix_mask(len1);
			m2 = prefix_mask(len2);
			for (int k = 0; k < 80; k++) begin
				// sender holds off until the pipeline is empty
				if (phase == 5 && k == 40)
					drain_results();
				r = $urandom_range(0, 19);
				if (r < 2) begin
					e = $urandom_range(0, TABLE_DEPTH - 1);
					j = $urandom_range(0, n_used - 1);
					if ($urandom_range(0, 1) == 0)
						send_item(load_item(e, $urandom, $urandom));
					else
						send_item(load_item(e, mutate_bases(code1_mem[j], 1, 16),
							mutate_bases(code2_mem[j], $urandom_range(0, 2), 16)));
				end else if (r == 2) begin
					send_item(read_pair($urandom, $urandom, $urandom_range(0, 31),
						$urandom_range(0, 31)));
				end else begin
					e = $urandom_range(0, n_used - 1);
					s1 = ($urandom & ~m1) | (code1_mem[e] & m1);
					s2 = ($urandom & ~m2) | (code2_mem[e] & m2);
					s1 = mutate_bases(s1, $urandom_range(0, 3), len1);
					s2 = mutate_bases(s2, $urandom_range(0, 3), len2);
					av1 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
						: $urandom_range(len1, 16);
					av2 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 16;
					send_item(read_pair(s1, s2, av1, av2));
				end
			end
		end
		sender_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	// output side: random stalls between transfers unless sink_steady is set
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = sink_steady ? 0 : $urandom_range(0, 9);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// compare each output transfer with the oldest queued outcome
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				$error("output transfer with no pending result: status %0d", m_axis_tuser);
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					mismatch_count++;
				end
				if (m_axis_tdata[5:0] !== want.index) begin
					$error("match_index: expected %0d, got %0d", want.index, m_axis_tdata[5:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[11:6] !== want.mm) begin
					$error("match_mm: expected %0d, got %0d", want.mm, m_axis_tdata[11:6]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PAIRED_MODE;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= FUNC_LOAD;
		active_cfg = '{1'b0, 5'd8, 5'd8, 6'd1, 5'd1, 5'd1, 7'd1};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_ties_and_extremes();
		test_paired_scoring();
		test_zero_length();
		test_table_fill();
		test_random_reads();

		drain_results();
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
